// File: sv/rssh_pkg.sv
// Shared types, register indexes and arithmetic helpers of the ray and sphere shader.
package rssh_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = CFG_IDX_W'(3);

    localparam logic [30:0] T_MAX    = 31'h7FFF_FFFF;
    localparam logic [15:0] CHAN_MAX = 16'hFFFF;
    localparam logic [15:0] CHAN_MID = 16'h7FFF;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] hit_distance;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } shade_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? n : v;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] p;
        p = x * y;
        return p;
    endfunction

    function automatic logic signed [63:0] smul32(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p;
    endfunction

    // 64x64 product from four 32x32 partials: lo*lo, lo*hi, hi*lo, hi*hi
    function automatic logic [127:0] join4(input logic [63:0] p00, input logic [63:0] p01,
                                           input logic [63:0] p10, input logic [63:0] p11);
        logic [127:0] s;
        s = {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {p11, 64'd0};
        return s;
    endfunction

endpackage

// File: sv/rssh_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a side tag.
module rssh_sqrt #(
    parameter int NW = 128,
    parameter int TW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [NW-1:0]   rad,
    input  logic [TW-1:0]   in_tag,
    output logic            out_vld,
    output logic [NW/2-1:0] root,
    output logic [TW-1:0]   out_tag
);

    localparam int RW = NW / 2;

    logic [NW-1:0] diff_reg [RW];
    logic [RW-1:0] root_reg [RW];
    logic [TW-1:0] tag_reg  [RW];
    logic [RW-1:0] vld_reg;

    logic [NW-1:0] diff_src  [RW];
    logic [NW-1:0] diff_next [RW];
    logic [RW-1:0] root_src  [RW];
    logic [RW-1:0] root_next [RW];
    logic [NW:0]   trial     [RW];

    // remainder n - r^2; bit b is kept when (r + 2^b)^2 <= n
    always_comb
    begin
        diff_src[0] = rad;
        root_src[0] = '0;
        for (int k = 1; k < RW; k++)
        begin
            diff_src[k] = diff_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
        for (int k = 0; k < RW; k++)
        begin
            trial[k] = ({1'b0, NW'(root_src[k])} << (RW - k))
                     + ((NW+1)'(1) << (2 * (RW - 1 - k)));
            if ({1'b0, diff_src[k]} >= trial[k])
            begin
                diff_next[k] = diff_src[k] - trial[k][NW-1:0];
                root_next[k] = root_src[k] | (RW'(1) << (RW - 1 - k));
            end
            else
            begin
                diff_next[k] = diff_src[k];
                root_next[k] = root_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RW-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < RW; k++)
                tag_reg[k] <= tag_reg[k-1];
            for (int k = 0; k < RW; k++)
            begin
                diff_reg[k] <= diff_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_vld = vld_reg[RW-1];
    assign root    = root_reg[RW-1];
    assign out_tag = tag_reg[RW-1];

endmodule

// File: sv/rssh_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes and a side tag.
module rssh_div #(
    parameter int LANES = 1,
    parameter int NW    = 80,
    parameter int DW    = 64,
    parameter int QW    = 16,
    parameter int TW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [LANES-1:0][DW-1:0]   den,
    input  logic [TW-1:0]              in_tag,
    output logic                       out_vld,
    output logic [LANES-1:0][QW-1:0]   quo,
    output logic [TW-1:0]              out_tag
);

    // quotient must fit QW bits (num < den * 2^QW); otherwise the result is don't-care
    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic [LANES-1:0][XW-1:0] rem_reg [QW];
    logic [LANES-1:0][DW-1:0] den_reg [QW];
    logic [LANES-1:0][QW-1:0] quo_reg [QW];
    logic [TW-1:0]            tag_reg [QW];
    logic [QW-1:0]            vld_reg;

    logic [LANES-1:0][XW-1:0] rem_src  [QW];
    logic [LANES-1:0][XW-1:0] rem_next [QW];
    logic [LANES-1:0][DW-1:0] den_src  [QW];
    logic [LANES-1:0][QW-1:0] quo_src  [QW];
    logic [LANES-1:0][QW-1:0] quo_next [QW];
    logic [LANES-1:0][XW-1:0] trial    [QW];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = XW'(num[l]);
            den_src[0][l] = den[l];
            quo_src[0][l] = '0;
        end
        for (int k = 1; k < QW; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            den_src[k] = den_reg[k-1];
            quo_src[k] = quo_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[k][l] = XW'(den_src[k][l]) << (QW - 1 - k);
                if (rem_src[k][l] >= trial[k][l])
                begin
                    rem_next[k][l] = rem_src[k][l] - trial[k][l];
                    quo_next[k][l] = quo_src[k][l] | (QW'(1) << (QW - 1 - k));
                end
                else
                begin
                    rem_next[k][l] = rem_src[k][l];
                    quo_next[k][l] = quo_src[k][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QW-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < QW; k++)
                tag_reg[k] <= tag_reg[k-1];
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quo     = quo_reg[QW-1];
    assign out_tag = tag_reg[QW-1];

endmodule

// File: sv/ray_sphere_normal_shade_unit.sv
// Ray against sphere intersection and shading pipeline: top level.
//
// Takes one ray transaction (origin and direction, signed fixed point with
// FRAC_BITS fraction bits) per clock and returns one shade transaction per ray,
// in order: hit flag, saturated distance t and an RGB color (surface normal
// mapped to 0.5*(n+1) on a hit, a vertical sky gradient on a miss). The sphere
// center and radius are set through the cfg port (index 0..3: center x, y, z,
// radius; other indexes are ignored); the user must write them only while no ray
// is in flight, which the block does not enforce. Throughput is one ray per cycle
// unless the pipeline holds; the bit-serial pipelines are the 64-stage square root
// of the discriminant, the 31-stage t divider, the 64-stage square root of the
// normal length, the 32-stage square root of |D|^2 and the 16-stage channel
// dividers, plus the multiply and add stages around them. A 2-entry output buffer
// lets the pipeline keep accepting rays while one result waits on shade_stall; the
// whole pipeline holds only when that buffer is full and a result sits at the end.
module ray_sphere_normal_shade_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ray_valid,
    output logic                            ray_stall,
    input  rssh_pkg::ray_t                  ray,
    output logic                            shade_valid,
    input  logic                            shade_stall,
    output rssh_pkg::shade_t                shade,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rssh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);

    import rssh_pkg::*;

    localparam int NUMW = 64 + FRAC_BITS;   // (|h| - sqrt) << FRAC_BITS
    localparam int SATW = 96;               // compare width for the t saturation test

    localparam logic signed [31:0] CZ_RESET  = -(32'sd1 <<< FRAC_BITS);
    localparam logic [30:0]        RAD_RESET = 31'd1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [31:0] ocx;
        logic signed [31:0] ocy;
        logic signed [31:0] ocz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } geom_t;

    typedef struct packed {
        geom_t       g;
        logic [63:0] a;
        logic [63:0] hmag;
        logic        ok;
    } disc_tag_t;

    typedef struct packed {
        geom_t       g;
        logic [63:0] a;
        logic        hit;
        logic        sat;
    } t_tag_t;

    typedef struct packed {
        logic              hit;
        logic [30:0]       t;
        logic [63:0]       a;
        logic signed [31:0] dy;
        logic [2:0]        neg;
        logic [2:0][63:0]  m;
    } norm_tag_t;

    typedef struct packed {
        norm_tag_t   b;
        logic [63:0] len_norm;
    } sky_tag_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] t;
        logic        lz;
    } chan_tag_t;

    // ---------------- configuration registers
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        rad_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= CZ_RESET;
            rad_reg <= RAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X: cx_reg  <= cfg_data;
                CFG_CENTER_Y: cy_reg  <= cfg_data;
                CFG_CENTER_Z: cz_reg  <= cfg_data;
                CFG_RADIUS:   rad_reg <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // ---------------- global advance and output buffer
    logic   adv;
    logic   pop;
    logic   push;
    logic   p15_vld_reg;
    shade_t p15_shade_reg;
    shade_t fifo_reg [2];
    logic   wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign pop         = shade_valid && !shade_stall;
    assign adv         = !p15_vld_reg || (cnt_reg != 2'd2) || pop;
    assign push        = adv && p15_vld_reg;
    assign ray_stall   = !adv;
    assign shade_valid = (cnt_reg != 2'd0);
    assign shade       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= p15_shade_reg;
    end

    // ---------------- front: oc, products, dot products, discriminant
    logic        p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic        p5_vld_reg, p6_vld_reg, p7_vld_reg;
    geom_t       p1_g_reg, p1_g_next;
    geom_t       p2_g_reg, p3_g_reg, p4_g_reg, p5_g_reg, p6_g_reg;

    logic [63:0] p2_dd_reg [3];
    logic [63:0] p2_oo_reg [3];
    logic [63:0] p2_od_reg [3];
    logic [2:0]  p2_odn_reg;
    logic [61:0] p2_rr_reg;

    logic [63:0] p3_a_reg, p3_cc_reg, p3_hpos_reg, p3_hneg_reg;
    logic [61:0] p3_rr_reg;

    logic [63:0] p4_a_reg, p4_hmag_reg, p4_cmag_reg;
    logic        p4_hneg_reg, p4_cneg_reg;

    logic [63:0] p5_a_reg, p5_hmag_reg;
    logic        p5_hneg_reg, p5_cneg_reg;
    logic [63:0] p5_hh_reg [4];
    logic [63:0] p5_ac_reg [4];

    logic [63:0]  p6_a_reg, p6_hmag_reg;
    logic         p6_ok_reg, p6_cneg_reg;
    logic [127:0] p6_hh_reg, p6_ac_reg;

    logic [127:0] p7_disc_reg;
    disc_tag_t    p7_tag_reg;

    // stage 1 combinational: oc = O - C saturated
    always_comb
    begin
        p1_g_next.ocx = sat33($signed({ray.origin_x[31], ray.origin_x})
                              - $signed({cx_reg[31], cx_reg}));
        p1_g_next.ocy = sat33($signed({ray.origin_y[31], ray.origin_y})
                              - $signed({cy_reg[31], cy_reg}));
        p1_g_next.ocz = sat33($signed({ray.origin_z[31], ray.origin_z})
                              - $signed({cz_reg[31], cz_reg}));
        p1_g_next.dx  = ray.dir_x;
        p1_g_next.dy  = ray.dir_y;
        p1_g_next.dz  = ray.dir_z;
    end

    // stage 2 combinational: magnitude products
    logic signed [31:0] oc_a [3];
    logic signed [31:0] d_a  [3];
    logic [31:0]        moc  [3];
    logic [31:0]        md   [3];

    always_comb
    begin
        oc_a[0] = p1_g_reg.ocx;
        oc_a[1] = p1_g_reg.ocy;
        oc_a[2] = p1_g_reg.ocz;
        d_a[0]  = p1_g_reg.dx;
        d_a[1]  = p1_g_reg.dy;
        d_a[2]  = p1_g_reg.dz;
        for (int i = 0; i < 3; i++)
        begin
            moc[i] = mag32(oc_a[i]);
            md[i]  = mag32(d_a[i]);
        end
    end

    // stage 3/4 combinational sums
    logic [63:0] hpos_c, hneg_c;

    always_comb
    begin
        hpos_c = '0;
        hneg_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (p2_odn_reg[i])
                hneg_c = hneg_c + p2_od_reg[i];
            else
                hpos_c = hpos_c + p2_od_reg[i];
        end
    end

    logic [63:0] rr64;
    assign rr64 = {2'b00, p3_rr_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_g_reg <= p1_g_next;

            p2_g_reg <= p1_g_reg;
            for (int i = 0; i < 3; i++)
            begin
                p2_dd_reg[i]  <= mul32(md[i], md[i]);
                p2_oo_reg[i]  <= mul32(moc[i], moc[i]);
                p2_od_reg[i]  <= mul32(moc[i], md[i]);
                p2_odn_reg[i] <= oc_a[i][31] != d_a[i][31];
            end
            p2_rr_reg <= 62'(mul32({1'b0, rad_reg}, {1'b0, rad_reg}));

            p3_g_reg    <= p2_g_reg;
            p3_a_reg    <= p2_dd_reg[0] + p2_dd_reg[1] + p2_dd_reg[2];
            p3_cc_reg   <= p2_oo_reg[0] + p2_oo_reg[1] + p2_oo_reg[2];
            p3_hpos_reg <= hpos_c;
            p3_hneg_reg <= hneg_c;
            p3_rr_reg   <= p2_rr_reg;

            p4_g_reg    <= p3_g_reg;
            p4_a_reg    <= p3_a_reg;
            p4_hneg_reg <= p3_hneg_reg > p3_hpos_reg;
            p4_hmag_reg <= (p3_hneg_reg > p3_hpos_reg) ? p3_hneg_reg - p3_hpos_reg
                                                       : p3_hpos_reg - p3_hneg_reg;
            p4_cneg_reg <= rr64 > p3_cc_reg;
            p4_cmag_reg <= (rr64 > p3_cc_reg) ? rr64 - p3_cc_reg : p3_cc_reg - rr64;

            // 64x64 products split into 32x32 partials
            p5_g_reg    <= p4_g_reg;
            p5_a_reg    <= p4_a_reg;
            p5_hmag_reg <= p4_hmag_reg;
            p5_hneg_reg <= p4_hneg_reg;
            p5_cneg_reg <= p4_cneg_reg;
            p5_hh_reg[0] <= mul32(p4_hmag_reg[31:0],  p4_hmag_reg[31:0]);
            p5_hh_reg[1] <= mul32(p4_hmag_reg[31:0],  p4_hmag_reg[63:32]);
            p5_hh_reg[2] <= mul32(p4_hmag_reg[63:32], p4_hmag_reg[31:0]);
            p5_hh_reg[3] <= mul32(p4_hmag_reg[63:32], p4_hmag_reg[63:32]);
            p5_ac_reg[0] <= mul32(p4_a_reg[31:0],  p4_cmag_reg[31:0]);
            p5_ac_reg[1] <= mul32(p4_a_reg[31:0],  p4_cmag_reg[63:32]);
            p5_ac_reg[2] <= mul32(p4_a_reg[63:32], p4_cmag_reg[31:0]);
            p5_ac_reg[3] <= mul32(p4_a_reg[63:32], p4_cmag_reg[63:32]);

            p6_g_reg    <= p5_g_reg;
            p6_a_reg    <= p5_a_reg;
            p6_hmag_reg <= p5_hmag_reg;
            p6_ok_reg   <= (p5_a_reg != 64'd0) && p5_hneg_reg;
            p6_cneg_reg <= p5_cneg_reg;
            p6_hh_reg   <= join4(p5_hh_reg[0], p5_hh_reg[1], p5_hh_reg[2], p5_hh_reg[3]);
            p6_ac_reg   <= join4(p5_ac_reg[0], p5_ac_reg[1], p5_ac_reg[2], p5_ac_reg[3]);

            // disc = h*h - a*c, wraps at 128 bits when c is negative
            p7_disc_reg     <= p6_cneg_reg ? p6_hh_reg + p6_ac_reg : p6_hh_reg - p6_ac_reg;
            p7_tag_reg.g    <= p6_g_reg;
            p7_tag_reg.a    <= p6_a_reg;
            p7_tag_reg.hmag <= p6_hmag_reg;
            p7_tag_reg.ok   <= p6_ok_reg && (p6_cneg_reg || (p6_ac_reg <= p6_hh_reg));
        end
    end

    // ---------------- sqrt of the discriminant
    logic        s1_vld;
    logic [63:0] s1_root;
    disc_tag_t   s1_tag;

    rssh_sqrt #(
        .NW (128),
        .TW ($bits(disc_tag_t))
    ) u_sqrt_disc (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (p7_vld_reg),
        .rad     (p7_disc_reg),
        .in_tag  (p7_tag_reg),
        .out_vld (s1_vld),
        .root    (s1_root),
        .out_tag (s1_tag)
    );

    // ---------------- t = (|h| - sqrt) << F / a
    logic            p8_vld_reg;
    logic [NUMW-1:0] p8_num_reg;
    t_tag_t          p8_tag_reg;
    logic [63:0]     num_c;
    logic [NUMW-1:0] nsh_c;

    assign num_c = s1_tag.hmag - s1_root;
    assign nsh_c = NUMW'(num_c) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_num_reg     <= nsh_c;
            p8_tag_reg.g   <= s1_tag.g;
            p8_tag_reg.a   <= s1_tag.a;
            p8_tag_reg.hit <= s1_tag.ok && (s1_tag.hmag > s1_root);
            p8_tag_reg.sat <= SATW'(nsh_c) >= (SATW'(s1_tag.a) << 31);
        end
    end

    logic        d1_vld;
    logic [30:0] d1_quo;
    t_tag_t      d1_tag;

    rssh_div #(
        .LANES (1),
        .NW    (NUMW),
        .DW    (64),
        .QW    (31),
        .TW    ($bits(t_tag_t))
    ) u_div_t (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (p8_vld_reg),
        .num     (p8_num_reg),
        .den     (p8_tag_reg.a),
        .in_tag  (p8_tag_reg),
        .out_vld (d1_vld),
        .quo     (d1_quo),
        .out_tag (d1_tag)
    );

    // ---------------- normal: v = oc << F + t*d, m = |v| >> 2, sum of m^2
    logic        p9_vld_reg, p10_vld_reg, p11_vld_reg, p12_vld_reg, p13_vld_reg;
    logic [30:0] t_c;
    logic [30:0] p9_t_reg;
    logic        p9_hit_reg;
    geom_t       p9_g_reg;
    logic [63:0] p9_a_reg;
    logic signed [63:0] p9_prod_reg [3];

    assign t_c = d1_tag.hit ? (d1_tag.sat ? T_MAX : d1_quo) : 31'd0;

    logic signed [31:0] oc9 [3];
    logic signed [64:0] v_c [3];
    logic [64:0]        vm_c [3];

    always_comb
    begin
        oc9[0] = p9_g_reg.ocx;
        oc9[1] = p9_g_reg.ocy;
        oc9[2] = p9_g_reg.ocz;
        for (int i = 0; i < 3; i++)
        begin
            v_c[i]  = ({{33{oc9[i][31]}}, oc9[i]} << FRAC_BITS)
                    + {p9_prod_reg[i][63], p9_prod_reg[i]};
            vm_c[i] = v_c[i][64] ? 65'd0 - v_c[i] : v_c[i];
        end
    end

    norm_tag_t   p10_tag_reg, p11_tag_reg, p12_tag_reg, p13_tag_reg;
    logic [63:0]  p11_mp_reg [3][4];
    logic [127:0] p12_sq_reg [3];
    logic [127:0] p13_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p9_t_reg       <= t_c;
            p9_hit_reg     <= d1_tag.hit;
            p9_g_reg       <= d1_tag.g;
            p9_a_reg       <= d1_tag.a;
            p9_prod_reg[0] <= smul32($signed({1'b0, t_c}), d1_tag.g.dx);
            p9_prod_reg[1] <= smul32($signed({1'b0, t_c}), d1_tag.g.dy);
            p9_prod_reg[2] <= smul32($signed({1'b0, t_c}), d1_tag.g.dz);

            p10_tag_reg.hit <= p9_hit_reg;
            p10_tag_reg.t   <= p9_t_reg;
            p10_tag_reg.a   <= p9_a_reg;
            p10_tag_reg.dy  <= p9_g_reg.dy;
            for (int i = 0; i < 3; i++)
            begin
                p10_tag_reg.neg[i] <= v_c[i][64];
                p10_tag_reg.m[i]   <= {1'b0, vm_c[i][64:2]};
            end

            p11_tag_reg <= p10_tag_reg;
            for (int i = 0; i < 3; i++)
            begin
                p11_mp_reg[i][0] <= mul32(p10_tag_reg.m[i][31:0],  p10_tag_reg.m[i][31:0]);
                p11_mp_reg[i][1] <= mul32(p10_tag_reg.m[i][31:0],  p10_tag_reg.m[i][63:32]);
                p11_mp_reg[i][2] <= mul32(p10_tag_reg.m[i][63:32], p10_tag_reg.m[i][31:0]);
                p11_mp_reg[i][3] <= mul32(p10_tag_reg.m[i][63:32], p10_tag_reg.m[i][63:32]);
            end

            p12_tag_reg <= p11_tag_reg;
            for (int i = 0; i < 3; i++)
                p12_sq_reg[i] <= join4(p11_mp_reg[i][0], p11_mp_reg[i][1],
                                       p11_mp_reg[i][2], p11_mp_reg[i][3]);

            p13_tag_reg <= p12_tag_reg;
            p13_sum_reg <= p12_sq_reg[0] + p12_sq_reg[1] + p12_sq_reg[2];
        end
    end

    // ---------------- L = sqrt(sum m^2), then len = sqrt(a) for the sky
    logic        s2_vld;
    logic [63:0] s2_root;
    norm_tag_t   s2_tag;
    sky_tag_t    s2_sky_tag;

    rssh_sqrt #(
        .NW (128),
        .TW ($bits(norm_tag_t))
    ) u_sqrt_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (p13_vld_reg),
        .rad     (p13_sum_reg),
        .in_tag  (p13_tag_reg),
        .out_vld (s2_vld),
        .root    (s2_root),
        .out_tag (s2_tag)
    );

    assign s2_sky_tag.b        = s2_tag;
    assign s2_sky_tag.len_norm = s2_root;

    logic        s3_vld;
    logic [31:0] s3_root;
    sky_tag_t    s3_tag;

    rssh_sqrt #(
        .NW (64),
        .TW ($bits(sky_tag_t))
    ) u_sqrt_sky (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s2_vld),
        .rad     (s2_tag.a),
        .in_tag  (s2_sky_tag),
        .out_vld (s3_vld),
        .root    (s3_root),
        .out_tag (s3_tag)
    );

    // ---------------- channel numerators and denominators
    // lanes 0..2: normal channels (L +/- m)*65535 / 2L; 3: sky red; 4: sky green
    logic [63:0]              lnorm_c;
    logic [63:0]              n_c [3];
    logic [31:0]              lenx_c;
    logic [33:0]              u_c;
    logic signed [33:0]       usum_c;
    logic [49:0]              numr_c;
    logic [4:0][79:0]         cnum_c;
    logic [4:0][63:0]         cden_c;

    always_comb
    begin
        lnorm_c = s3_tag.len_norm;
        for (int i = 0; i < 3; i++)
        begin
            n_c[i] = s3_tag.b.neg[i] ? lnorm_c - s3_tag.b.m[i] : lnorm_c + s3_tag.b.m[i];
            cnum_c[i] = {n_c[i], 16'd0} - {16'd0, n_c[i]};
            cden_c[i] = {lnorm_c[62:0], 1'b0};
        end
        usum_c = $signed({{2{s3_tag.b.dy[31]}}, s3_tag.b.dy}) + $signed({2'b00, s3_root});
        if (s3_root == 32'd0)
        begin
            lenx_c = 32'd1;
            u_c    = 34'd1;
        end
        else
        begin
            lenx_c = s3_root;
            u_c    = usum_c;      // 0 <= dy + len <= 2*len
        end
        numr_c    = {u_c, 16'd0} - {16'd0, u_c};
        cnum_c[3] = 80'(numr_c);
        cnum_c[4] = 80'({numr_c, 1'b0}) + 80'(numr_c);
        cden_c[3] = 64'({lenx_c, 2'b00});
        cden_c[4] = 64'({lenx_c, 4'b0000}) + 64'({lenx_c, 2'b00});
    end

    logic             p14_vld_reg;
    logic [4:0][79:0] p14_num_reg;
    logic [4:0][63:0] p14_den_reg;
    chan_tag_t        p14_tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p14_num_reg     <= cnum_c;
            p14_den_reg     <= cden_c;
            p14_tag_reg.hit <= s3_tag.b.hit;
            p14_tag_reg.t   <= s3_tag.b.t;
            p14_tag_reg.lz  <= lnorm_c == 64'd0;
        end
    end

    logic             d2_vld;
    logic [4:0][15:0] d2_quo;
    chan_tag_t        d2_tag;

    rssh_div #(
        .LANES (5),
        .NW    (80),
        .DW    (64),
        .QW    (16),
        .TW    ($bits(chan_tag_t))
    ) u_div_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (p14_vld_reg),
        .num     (p14_num_reg),
        .den     (p14_den_reg),
        .in_tag  (p14_tag_reg),
        .out_vld (d2_vld),
        .quo     (d2_quo),
        .out_tag (d2_tag)
    );

    // ---------------- final select
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p15_shade_reg.hit          <= d2_tag.hit;
            p15_shade_reg.hit_distance <= d2_tag.t;
            if (d2_tag.hit)
            begin
                // degenerate normal length reads as mid gray
                p15_shade_reg.red   <= d2_tag.lz ? CHAN_MID : d2_quo[0];
                p15_shade_reg.green <= d2_tag.lz ? CHAN_MID : d2_quo[1];
                p15_shade_reg.blue  <= d2_tag.lz ? CHAN_MID : d2_quo[2];
            end
            else
            begin
                p15_shade_reg.red   <= CHAN_MAX - d2_quo[3];
                p15_shade_reg.green <= CHAN_MAX - d2_quo[4];
                p15_shade_reg.blue  <= CHAN_MAX;
            end
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            p7_vld_reg  <= 1'b0;
            p8_vld_reg  <= 1'b0;
            p9_vld_reg  <= 1'b0;
            p10_vld_reg <= 1'b0;
            p11_vld_reg <= 1'b0;
            p12_vld_reg <= 1'b0;
            p13_vld_reg <= 1'b0;
            p14_vld_reg <= 1'b0;
            p15_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg  <= ray_valid;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            p5_vld_reg  <= p4_vld_reg;
            p6_vld_reg  <= p5_vld_reg;
            p7_vld_reg  <= p6_vld_reg;
            p8_vld_reg  <= s1_vld;
            p9_vld_reg  <= d1_vld;
            p10_vld_reg <= p9_vld_reg;
            p11_vld_reg <= p10_vld_reg;
            p12_vld_reg <= p11_vld_reg;
            p13_vld_reg <= p12_vld_reg;
            p14_vld_reg <= s3_vld;
            p15_vld_reg <= d2_vld;
        end
    end

endmodule
